// ----- rtl/sbsh_pkg.sv -----
`timescale 1ns / 1ps
// shared types, round constants and sigma functions for the sha-256 byte stream hasher
// no dependencies; imported by sha256_byte_stream_hasher

package sbsh_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    // padding phases: end marker, zero fill, bit length
    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } pad_phase_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- rtl/sha256_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// sha-256 over a byte stream: byte gathering, padding sequencer, one round per cycle
// depends on sbsh_pkg (state types, round constants, sigma functions)
//
//  channel   handshake                     payload
//  -------   ---------------------------   ----------------------------------------
//  byte in   byte_valid / byte_stall       data_byte, byte_present, end_message
//  digest    digest_valid / digest_stall   digest_word, word_index, last_word
//
// a transfer that fills the block starts a compression (64 rounds on the shared
// round unit, then one chaining add).
// end_message pads one byte per cycle to the end of the block (over two blocks, with
// a compression between them, when the length does not fit), compresses the last
// block and sends 8 digest words. the byte channel stalls from a transfer that
// fills the block or ends a message until the block is idle again.
// the digest channel holds its word while digest_stall is high.
// asynchronous reset loads the initial hash values and clears the length and fill.

module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sbsh_pkg::*;

    state_t      state_reg, state_next;
    pad_phase_t  phase_reg;
    logic        pad_act_reg;
    logic [5:0]  fill_reg;
    logic [60:0] len_reg;
    logic [5:0]  round_reg;
    logic [2:0]  emit_idx_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] work_reg  [8];
    logic [31:0] w_reg     [16];
    logic [23:0] acc_reg;

    // control decoded from state
    logic        accept;
    logic        ins_en;
    logic [7:0]  ins_byte;
    logic        block_full;
    logic        emit_xfer;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;

    // round datapath
    logic [31:0] t1, t2, w_new, shift_in;
    logic        shift_en;

    assign accept     = byte_valid && (state_reg == ST_IDLE);
    assign emit_xfer  = (state_reg == ST_EMIT) && !digest_stall;
    assign block_full = ins_en && (fill_reg == LAST_SLOT);
    assign len_bits   = {len_reg, 3'b000};
    assign len_byte   = len_bits[{~fill_reg[2:0], 3'b000} +: 8];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present && (fill_reg == LAST_SLOT))
                        state_next = ST_ROUND;
                    else if (end_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LAST_SLOT)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (phase_reg == PH_LEN)
                    state_next = ST_EMIT;
                else if (pad_act_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!digest_stall && (emit_idx_reg == LAST_WORD_IDX))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // byte insertion source
    always_comb
    begin
        ins_en   = 1'b0;
        ins_byte = data_byte;
        case (state_reg)
            ST_IDLE:
            begin
                ins_en   = accept && byte_present;
                ins_byte = data_byte;
            end
            ST_PAD:
            begin
                ins_en = 1'b1;
                if (phase_reg == PH_MARK)
                    ins_byte = PAD_MARK;
                else if ((phase_reg == PH_ZERO) && (fill_reg != LEN_START))
                    ins_byte = 8'h00;
                else
                    ins_byte = len_byte;
            end
            default:
            begin
                ins_en   = 1'b0;
                ins_byte = data_byte;
            end
        endcase
    end

    // handshake and digest outputs
    assign byte_stall   = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_EMIT);
    assign digest_word  = chain_reg[emit_idx_reg];
    assign word_index   = emit_idx_reg;
    assign last_word    = (emit_idx_reg == LAST_WORD_IDX);

    // one compression round and one schedule word
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + w_reg[0];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));
    assign w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);

    // schedule window shifts on a completed word or on each round
    assign shift_en = (ins_en && (fill_reg[1:0] == 2'b11)) || (state_reg == ST_ROUND);
    assign shift_in = (state_reg == ST_ROUND) ? w_new : {acc_reg, ins_byte};

    // control registers and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_MARK;
            pad_act_reg  <= 1'b0;
            fill_reg     <= '0;
            len_reg      <= '0;
            round_reg    <= '0;
            emit_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= INIT_H[i];
        end
        else
        begin
            state_reg <= state_next;

            // item acceptance
            if (accept)
            begin
                pad_act_reg <= end_message;
                phase_reg   <= PH_MARK;
                if (byte_present)
                    len_reg <= len_reg + 61'd1;
            end

            // padding phase steps
            if (state_reg == ST_PAD)
            begin
                if (phase_reg == PH_MARK)
                    phase_reg <= PH_ZERO;
                else if ((phase_reg == PH_ZERO) && (fill_reg == LEN_START))
                    phase_reg <= PH_LEN;
            end

            if (ins_en)
                fill_reg <= fill_reg + 6'd1;

            // round counter
            if (state_reg == ST_ROUND)
                round_reg <= round_reg + 6'd1;
            else
                round_reg <= '0;

            // chaining add after the last round
            if (state_reg == ST_FINAL)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end

            // digest word transfer, back to a fresh message after the last one
            if (emit_xfer)
            begin
                emit_idx_reg <= emit_idx_reg + 3'd1;
                if (emit_idx_reg == LAST_WORD_IDX)
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= INIT_H[i];
                    len_reg     <= '0;
                    fill_reg    <= '0;
                    pad_act_reg <= 1'b0;
                    phase_reg   <= PH_MARK;
                end
            end
        end
    end

    // datapath registers: byte gather, schedule window, working variables
    always_ff @(posedge clk)
    begin
        if (ins_en)
            acc_reg <= {acc_reg[15:0], ins_byte};

        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= shift_in;
        end

        if (block_full)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

endmodule

// ----- bench/sha256_byte_stream_hasher_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for sha256_byte_stream_hasher: directed table plus random messages
// depends only on the hasher rtl; digests are predicted by a behavioral sha-256 kept here

module sha256_byte_stream_hasher_tb;

    localparam int CLK_HALF        = 4;
    localparam int RANDOM_ITEMS    = 300;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 200;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int GAP_PERCENT     = 25;

    localparam logic [7:0] END_MARK = 8'h80;
    localparam int         LEN_SLOT = 56;

    // known digests of the empty message and of "abc"
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [255:0] SHA_IV =
        256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // message lengths around the padding and block boundaries
    localparam int EDGE_LENGTHS [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 128};

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         fin;
        logic         typed;
        logic [255:0] digest;
    } stim_row_t;

    // directed rows: empty message, idle items, "abc", extremes of the byte,
    // end with no byte, back-to-back messages
    localparam int DIRECTED_ROWS = 13;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'ha5, 1'b0, 1'b1, 1'b0, 256'h0},
        '{8'h3c, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_message = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  block_bytes [64];
    logic [5:0]  block_count;
    logic [60:0] msg_bytes;
    logic [255:0] model_digest;

    digest_beat_t pending_words [$];
    digest_beat_t head_beat;

    int  fail_count = 0;
    int  words_checked = 0;
    int  byte_xfers = 0;
    int  msg_count = 0;
    int  quiet_cycles = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    bit  gaps_on = 1'b1;

    sha256_byte_stream_hasher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .end_message  (end_message),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // back to the start of a message
    function automatic void hash_restart();
        int i;
        for (i = 0; i < 8; i++)
        begin
            chain_h[i] = SHA_IV[255 - 32 * i -: 32];
        end
        block_count = '0;
        msg_bytes   = '0;
    endfunction

    // one 64-round compression of block_bytes into chain_h
    function automatic void hash_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++)
        begin
            w[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
                    block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
        end
        for (i = 16; i < 64; i++)
        begin
            s0 = rot_right(w[i - 15], 7) ^ rot_right(w[i - 15], 18) ^ (w[i - 15] >> 3);
            s1 = rot_right(w[i - 2], 17) ^ rot_right(w[i - 2], 19) ^ (w[i - 2] >> 10);
            w[i] = w[i - 16] + s0 + w[i - 7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (i = 0; i < 64; i++)
        begin
            t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
                 + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
            t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    // absorb one transfer; returns 1 and fills model_digest when a digest is due
    function automatic bit hash_absorb(input logic [7:0] d, input logic p, input logic fin);
        logic [63:0] bit_len;
        int pos;
        int i;
        if (p)
        begin
            block_bytes[block_count] = d;
            block_count = block_count + 6'd1;
            msg_bytes   = msg_bytes + 61'd1;
            if (block_count == 6'd0)
                hash_block();
        end
        if (!fin)
            return 1'b0;
        bit_len = {msg_bytes, 3'b000};
        pos = int'(block_count);
        block_bytes[pos] = END_MARK;
        pos = pos + 1;
        // no room for the length: close this block and pad a second one
        if (pos > LEN_SLOT)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = 8'h00;
                pos = pos + 1;
            end
            hash_block();
            pos = 0;
        end
        while (pos < LEN_SLOT)
        begin
            block_bytes[pos] = 8'h00;
            pos = pos + 1;
        end
        for (i = 0; i < 8; i++)
        begin
            block_bytes[63 - i] = bit_len[8 * i +: 8];
        end
        hash_block();
        model_digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                        chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
        hash_restart();
        return 1'b1;
    endfunction

    // offer one transfer until accepted, then queue the digest words if it ends a message
    task automatic send_item(input logic [7:0] d, input logic p, input logic fin,
                             input logic typed, input logic [255:0] typed_digest);
        logic [255:0] dg;
        digest_beat_t beat;
        int k;
        if (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        byte_valid   <= 1'b1;
        data_byte    <= d;
        byte_present <= p;
        end_message  <= fin;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        byte_xfers++;
        if (hash_absorb(d, p, fin))
        begin
            dg = typed ? typed_digest : model_digest;
            for (k = 0; k < 8; k++)
            begin
                beat.word = dg[255 - 32 * k -: 32];
                beat.idx  = k[2:0];
                beat.last = (k == 7);
                pending_words.push_back(beat);
            end
        end
    endtask

    // drop valid and wait for every outstanding digest word
    task automatic idle_until_drained();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // digest receiver: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (digest_valid && !digest_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected digest word %h (index %0d)", digest_word, word_index);
                fail_count++;
            end
            else
            begin
                head_beat = pending_words.pop_front();
                words_checked++;
                if (digest_word !== head_beat.word)
                begin
                    $error("digest_word: expected %h, actual %h", head_beat.word, digest_word);
                    fail_count++;
                end
                if (word_index !== head_beat.idx)
                begin
                    $error("word_index: expected %0d, actual %0d", head_beat.idx, word_index);
                    fail_count++;
                end
                if (last_word !== head_beat.last)
                begin
                    $error("last_word: expected %0b, actual %0b", head_beat.last, last_word);
                    fail_count++;
                end
            end
        end
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            digest_stall <= 1'b1;
        end
        else if (gaps_on)
            digest_stall <= ($urandom_range(99) < GAP_PERCENT);
        else
            digest_stall <= 1'b0;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (digest_valid && !digest_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("timeout: %0d cycles without a transfer", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int row;
        int items_sent;
        int len;
        int b;
        bit end_on_byte;
        bit closing;

        hash_restart();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            send_item(DIRECTED[row].data, DIRECTED[row].present, DIRECTED[row].fin,
                      DIRECTED[row].typed, DIRECTED[row].digest);
        end
        idle_until_drained();

        // random messages, biased toward padding boundaries, with idle noise
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(2) == 0)
                len = EDGE_LENGTHS[$urandom_range(9)];
            else
                len = $urandom_range(40);
            end_on_byte = (len > 0) && ($urandom_range(1) == 1);
            gaps_on = !(msg_count >= 4 && msg_count <= 6);
            if (msg_count == 8)
                idle_until_drained();
            for (b = 0; b < len; b++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
                closing = end_on_byte && (b == len - 1);
                // long digest hold-off at the end of the third message; the byte channel stalls meanwhile
                if (closing && msg_count == 2)
                    hold_asked++;
                send_item(8'($urandom_range(255)), 1'b1, closing, 1'b0, '0);
                items_sent++;
            end
            if (!end_on_byte)
            begin
                if (msg_count == 2)
                    hold_asked++;
                send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
                items_sent++;
            end
            msg_count++;
        end
        gaps_on = 1'b1;

        idle_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d directed rows and %0d random messages: %0d byte transfers,",
                 DIRECTED_ROWS, msg_count, byte_xfers);
        $display("%0d digest words checked, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
